[design/wts_pkg.sv]
// ----------------------------------------------------------------------------
// wts_pkg: shared types and constants for the text word splitter
// Beat layouts for both channels, register indexes, token kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

  localparam int MAX_SEPARATORS_DEF = 8;
  localparam int POS_W              = 9;

  localparam logic [7:0]       SPACE_CHAR = 8'h20;
  localparam logic [POS_W-1:0] POS_MAX    = 9'd511;

  localparam logic [1:0] REG_MAX_WORDS       = 2'd0;
  localparam logic [1:0] REG_SEPARATOR_COUNT = 2'd1;
  localparam logic [1:0] REG_SEPARATOR_CHARS = 2'd2;
  localparam logic [1:0] REG_OFFSET_BIAS     = 2'd3;

  localparam logic [1:0] KIND_WORD      = 2'd0;
  localparam logic [1:0] KIND_SEPARATOR = 2'd1;
  localparam logic [1:0] KIND_END       = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_start;
    logic [7:0] token_length;
    logic [7:0] token_count;
    logic       last;
  } out_t;

endpackage

`default_nettype wire

[design/text_word_splitter.sv]
// An accepted beat is registered in the input register, then its results are
// written to the result buffer, whose head slot0 drives the output.
// Throughput: one input beat per cycle while each causes at most one result
// and out_stall is low; a beat with two results holds the input until the
// single result port is popping the last entry of the two-entry result buffer.
// Reset (rst, synchronous): config returns to its defaults, text state clears.
// ----------------------------------------------------------------------------
// text_word_splitter: character stream to word and separator tokens
// Splits text on spaces and configured separators, one character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module text_word_splitter #(
  parameter int MAX_SEPARATORS = wts_pkg::MAX_SEPARATORS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         in_valid,
  output      logic         in_stall,
  input  wire wts_pkg::in_t in_data,
  output      logic         out_valid,
  input  wire logic         out_stall,
  output wts_pkg::out_t     out_data
);
  import wts_pkg::*;

  // configuration
  logic [7:0]  max_words;
  logic [3:0]  sep_count;
  logic [63:0] sep_chars;
  logic [1:0]  offset_bias;

  // text state
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] word_begin;
  logic [7:0]       tokens_done;

  // input register
  logic s1_valid;
  in_t  s1_data;
  logic s1_adv;

  // result buffer, slot0 is the head
  out_t       slot0, slot1;
  logic [1:0] count;
  logic       pop;

  // combinational results
  out_t             r0, r1;
  logic [1:0]       n_res;
  logic [POS_W-1:0] position_next, word_begin_next, pos_inc;
  logic [7:0]       tokens_done_next;

  logic             is_sep, active, is_space, word_ok, sep_ok;
  logic [POS_W-1:0] word_len;
  logic [7:0]       len8, td1;
  out_t             word_tok, sep_tok, end_tok;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign out_data  = slot0;
  assign s1_adv    = s1_valid && ((count == 2'd0) || (count == 2'd1 && pop));
  assign in_stall  = s1_valid && !s1_adv;

  always_comb begin
    is_sep = 1'b0;
    for (int k = 0; k < MAX_SEPARATORS; k++) begin
      if ((4'(k) < sep_count) && (sep_chars[8*k +: 8] == s1_data.ch)) begin
        is_sep = 1'b1;
      end
    end
  end

  always_comb begin
    pos_inc  = (position >= POS_MAX) ? POS_MAX : position + 9'd1;
    active   = tokens_done < max_words;
    is_space = s1_data.ch == SPACE_CHAR;
    word_len = (position > word_begin) ? position - word_begin : '0;
    word_ok  = (word_len != '0) && active;
    len8     = (word_len > 9'd255) ? 8'hFF : word_len[7:0];
    td1      = tokens_done + {7'd0, word_ok};
    sep_ok   = td1 < max_words;

    word_tok = '{kind: KIND_WORD, token_start: word_begin[7:0] + {6'd0, offset_bias},
                 token_length: len8, token_count: tokens_done, last: 1'b0};
    sep_tok  = '{kind: KIND_SEPARATOR, token_start: position[7:0] + {6'd0, offset_bias},
                 token_length: 8'd1, token_count: td1, last: 1'b1};
    end_tok  = '{kind: KIND_END, token_start: 8'd0, token_length: 8'd0,
                 token_count: td1, last: 1'b1};

    r0               = word_tok;
    r1               = end_tok;
    n_res            = 2'd0;
    position_next    = pos_inc;
    word_begin_next  = word_begin;
    tokens_done_next = tokens_done;

    priority if (s1_data.end_of_text) begin
      position_next    = '0;
      word_begin_next  = '0;
      tokens_done_next = 8'd0;
      if (word_ok) begin
        r1    = end_tok;
        n_res = 2'd2;
      end else begin
        r0    = end_tok;
        n_res = 2'd1;
      end
    end else if (active && is_space) begin
      word_begin_next  = pos_inc;
      tokens_done_next = td1;
      r0.last          = 1'b1;
      n_res            = {1'b0, word_ok};
    end else if (active && is_sep) begin
      word_begin_next  = pos_inc;
      tokens_done_next = td1 + {7'd0, sep_ok};
      // drop whichever token the limit does not allow
      if (word_ok && sep_ok) begin
        r1    = sep_tok;
        n_res = 2'd2;
      end else if (word_ok) begin
        r0.last = 1'b1;
        n_res   = 2'd1;
      end else if (sep_ok) begin
        r0    = sep_tok;
        n_res = 2'd1;
      end
    end else begin
      n_res = 2'd0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_words   <= 8'd255;
      sep_count   <= 4'd0;
      sep_chars   <= 64'd0;
      offset_bias <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_WORDS:       max_words   <= cfg_data[7:0];
        REG_SEPARATOR_COUNT: sep_count   <= cfg_data[3:0];
        REG_SEPARATOR_CHARS: sep_chars   <= cfg_data;
        REG_OFFSET_BIAS:     offset_bias <= cfg_data[1:0];
      endcase
    end
  end

  // input register and text state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      position    <= '0;
      word_begin  <= '0;
      tokens_done <= 8'd0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        position    <= position_next;
        word_begin  <= word_begin_next;
        tokens_done <= tokens_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (s1_adv) begin
      count <= n_res;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");

  a_adv_drained: assert property (@(posedge clk) disable iff (rst)
    s1_adv |-> (count == 2'd0 || (count == 2'd1 && pop)))
    else $error("input advanced into a busy result buffer");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> (!slot0.last && slot1.last))
    else $error("result pair carries last on the wrong entry");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    count == 2'd1 |-> slot0.last)
    else $error("lone result without last");
`endif

endmodule

`default_nettype wire
